FILE: design/iovc_pkg.sv
// ----------------------------------------------------------------------------
// iovc_pkg
// shared constants, types and codes of the interval overlap counter
// ----------------------------------------------------------------------------
package iovc_pkg;

   localparam int MAX_INTERVALS = 1024;
   localparam int POS_WIDTH     = 32;

   // chain geometry: a power-of-two row of lanes, each with its own bank
   localparam int CELL_BITS  = 4;
   localparam int N_CELLS    = 1 << CELL_BITS;
   localparam int LANE_NEED  = (MAX_INTERVALS + N_CELLS - 1) / N_CELLS;
   localparam int ADDR_BITS  = (LANE_NEED > 2) ? $clog2(LANE_NEED) : 1;
   localparam int BANK_DEPTH = 1 << ADDR_BITS;
   localparam int IDX_W      = ADDR_BITS + CELL_BITS;

   // stored count and compare widths
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

   // result count field, saturating
   localparam int COUNT_W = 11;

   // item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef logic [POS_WIDTH-1:0] pos_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [ADDR_BITS-1:0] addr_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      pos_type  wr_start;
      pos_type  wr_end;
      addr_type rd_addr;
      logic     scan_en;
      logic     clear_acc;
      logic     shift;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_SETTLE = 4'b0100,
      ST_DRAIN  = 4'b1000
   } state_type;

endpackage

FILE: design/iovc_cell.sv
// ----------------------------------------------------------------------------
// iovc_cell
// one lane: a bank of stored intervals, an overlap compare and a local
// count that shifts down the chain when the scan is over
// ----------------------------------------------------------------------------
module iovc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  iovc_pkg::cell_ctrl_type ctrl,
   input  logic                    lane_wr,
   input  logic                    lane_live,
   input  iovc_pkg::pos_type       query_start,
   input  iovc_pkg::pos_type       query_end,
   input  iovc_pkg::count_type     acc_prev,
   output iovc_pkg::count_type     acc_out
);
   import iovc_pkg::*;

   pos_type   bank_start [BANK_DEPTH];
   pos_type   bank_end   [BANK_DEPTH];
   pos_type   rd_start_ff;
   pos_type   rd_end_ff;
   logic      hit_en_ff;
   count_type acc_ff;
   count_type acc_in;
   logic      overlap;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en && lane_wr) begin
         bank_start[ctrl.wr_addr] <= ctrl.wr_start;
         bank_end[ctrl.wr_addr]   <= ctrl.wr_end;
      end
      rd_start_ff <= bank_start[ctrl.rd_addr];
      rd_end_ff   <= bank_end[ctrl.rd_addr];
   end

   // closed intervals meet unless one lies wholly past the other
   assign overlap = !((query_end < rd_start_ff) || (query_start > rd_end_ff));

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear_acc) begin
         acc_in = '0;
      end else if (ctrl.shift) begin
         acc_in = acc_prev;
      end else if (hit_en_ff && overlap && (acc_ff != {COUNT_W{1'b1}})) begin
         acc_in = acc_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_en_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         hit_en_ff <= ctrl.scan_en && lane_live;
         acc_ff    <= acc_in;
      end
   end

   assign acc_out = acc_ff;

endmodule

FILE: design/interval_overlap_counter.sv
// ----------------------------------------------------------------------------
// interval_overlap_counter
// counts stored closed intervals that overlap each query interval
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per item. tuser carries the kind (load, query,
//   clear), tdata the interval, tlast the end-of-batch mark of a query.
//   rsp channel: one word per query, in arrival order, carrying the
//   saturating overlap count in tdata and the query's tlast.
//   loads and clears finish in the idle state; a load into a full set is dropped.
// structure
//   the set lives in a row of 16 lane cells, interval i in lane i mod 16 at
//   bank address i / 16. a query scans all bank addresses in parallel across
//   the lanes, waits in a settle state for the last registered bank read,
//   then shifts the lane counts down the chain into a total. one item is
//   in work at a time.
// reset and stall
//   reset empties the set and drops any pending result; bank contents are
//   left undefined and entries beyond the stored count are never counted.
//   a finished result sits in the output register; the block keeps taking
//   loads, clears and a new query while it waits, and a second query holds
//   its total until the register frees.
// ----------------------------------------------------------------------------
module interval_overlap_counter (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // range_start [31:0], range_end [63:32]
   input  logic [1:0]  req_tuser,   // kind [1:0]
   input  logic        req_tlast,   // last_item
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // overlap_count [10:0], zero fill [15:11]
   output logic        rsp_tlast    // last_query
);
   import iovc_pkg::*;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         stored_ff, stored_in;
   addr_type                 addr_ff, addr_in;
   logic [CELL_BITS-1:0]     drain_ff, drain_in;
   pos_type                  qstart_ff, qstart_in;
   pos_type                  qend_ff, qend_in;
   logic                     qlast_ff, qlast_in;
   count_type                total_ff, total_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   count_type                rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type            ctrl;
   logic [N_CELLS-1:0]       lane_wr;
   logic [N_CELLS-1:0]       lane_live;
   count_type                acc_chain [N_CELLS+1];

   logic                     req_fire;
   logic                     rsp_free;
   logic [IDX_W-1:0]         load_idx;
   pos_type                  in_start, in_end;
   logic [COUNT_W:0]         total_sum;

   // only the low position bits matter
   assign in_start = req_tdata[POS_WIDTH-1:0];
   assign in_end   = req_tdata[32+POS_WIDTH-1:32];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign load_idx   = IDX_W'(stored_ff);

   // drain: the last lane's count falls out of the chain into the total
   assign total_sum = {1'b0, total_ff} + {1'b0, acc_chain[N_CELLS]};

   always_comb begin
      state_in     = state_ff;
      stored_in    = stored_ff;
      addr_in      = addr_ff;
      drain_in     = drain_ff;
      qstart_in    = qstart_ff;
      qend_in      = qend_ff;
      qlast_in     = qlast_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      ctrl           = '0;
      ctrl.wr_addr   = load_idx[IDX_W-1:CELL_BITS];
      ctrl.wr_start  = in_start;
      ctrl.wr_end    = in_end;
      ctrl.rd_addr   = addr_ff;
      lane_wr        = '0;
      lane_live      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  KIND_LOAD: begin
                     // a full set drops the load
                     if (stored_ff < CNT_W'(MAX_INTERVALS)) begin
                        ctrl.wr_en                        = 1'b1;
                        lane_wr[load_idx[CELL_BITS-1:0]] = 1'b1;
                        stored_in                         = stored_ff + CNT_W'(1);
                     end
                  end
                  KIND_QUERY: begin
                     qstart_in      = in_start;
                     qend_in        = in_end;
                     qlast_in       = req_tlast;
                     addr_in        = '0;
                     total_in       = '0;
                     ctrl.clear_acc = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  KIND_CLEAR: begin
                     stored_in = '0;
                  end
                  default: begin
                     // unused kind: no effect
                  end
               endcase
            end
         end
         ST_SCAN: begin
            ctrl.scan_en = 1'b1;
            // a lane takes part only where its entry lies below the count
            for (int c = 0; c < N_CELLS; c++) begin
               lane_live[c] = CMP_W'({addr_ff, CELL_BITS'(c)}) < CMP_W'(stored_ff);
            end
            addr_in = addr_ff + ADDR_BITS'(1);
            if (&addr_ff) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            // last registered bank read lands in the lane counts
            drain_in = '0;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            ctrl.shift = 1'b1;
            total_in   = total_sum[COUNT_W] ? {COUNT_W{1'b1}} : total_sum[COUNT_W-1:0];
            if (&drain_ff) begin
               // chain is empty now, extra shifts only add zero
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = total_in;
                  rsp_last_in  = qlast_ff;
                  state_in     = ST_IDLE;
               end
            end else begin
               drain_in = drain_ff + CELL_BITS'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stored_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and sequencing registers, qualified by the state
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      drain_ff     <= drain_in;
      qstart_ff    <= qstart_in;
      qend_ff      <= qend_in;
      qlast_ff     <= qlast_in;
      total_ff     <= total_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // row of lane cells, counts shift toward the high end
   assign acc_chain[0] = '0;

   for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
      iovc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .lane_wr     (lane_wr[g]),
         .lane_live   (lane_live[g]),
         .query_start (qstart_ff),
         .query_end   (qend_ff),
         .acc_prev    (acc_chain[g]),
         .acc_out     (acc_chain[g+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-COUNT_W){1'b0}}, rsp_count_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the interval overlap counter: directed table, then
// random batches of loads, clears and queries, every query word checked
// against a typed or behavioral overlap count kept inside the bench
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iovc_pkg::*;

   // kind code that the block ignores
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 12;
   // random part stops once this many counted words were sent
   localparam int ITEM_TARGET  = 580;
   // last stretch of the run without any idling
   localparam int CALM_TAIL    = 60;
   // cycles after the last answer, well above one query scan
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int COUNT_CAP    = (1 << COUNT_W) - 1;

   // one row of the directed table
   typedef struct packed {
      logic [1:0] kind;
      pos_type    lo;
      pos_type    hi;
      logic       last;
      logic       known;     // count typed in below
      count_type  count;
   } step_row_type;

   // one answer the block still owes
   typedef struct packed {
      count_type count;
      logic      last;
   } query_answer_type;

   localparam int N_ROWS = 22;
   localparam step_row_type DIRECTED [N_ROWS] = '{
      // empty set answers zero
      '{KIND_QUERY, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 11'd0},
      '{KIND_LOAD,  32'd10,        32'd20,        1'b0, 1'b0, 11'd0},
      // shared end point counts as overlap
      '{KIND_QUERY, 32'd20,        32'd30,        1'b0, 1'b1, 11'd1},
      '{KIND_QUERY, 32'd21,        32'd30,        1'b0, 1'b1, 11'd0},
      '{KIND_QUERY, 32'd0,         32'd9,         1'b0, 1'b1, 11'd0},
      '{KIND_QUERY, 32'd0,         32'd10,        1'b1, 1'b1, 11'd1},
      // inverted query taken as given
      '{KIND_QUERY, 32'd30,        32'd0,         1'b0, 1'b1, 11'd0},
      // ignored kind must not load
      '{KIND_SPARE, 32'd5,         32'd15,        1'b1, 1'b0, 11'd0},
      '{KIND_QUERY, 32'd15,        32'd15,        1'b0, 1'b1, 11'd1},
      '{KIND_LOAD,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 11'd0},
      '{KIND_LOAD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0},
      // inverted stored interval
      '{KIND_LOAD,  32'd100,       32'd50,        1'b0, 1'b0, 11'd0},
      '{KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 11'd2},
      '{KIND_QUERY, 32'd60,        32'd70,        1'b0, 1'b0, 11'd0},
      '{KIND_QUERY, 32'd40,        32'd200,       1'b0, 1'b0, 11'd0},
      '{KIND_QUERY, 32'd0,         32'd0,         1'b1, 1'b0, 11'd0},
      '{KIND_CLEAR, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 11'd0},
      '{KIND_QUERY, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 11'd0},
      // clear of an empty set
      '{KIND_CLEAR, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 11'd0},
      '{KIND_LOAD,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 11'd0},
      '{KIND_QUERY, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 11'd0},
      '{KIND_CLEAR, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 11'd0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // range_start [31:0], range_end [63:32]
   logic [1:0]  req_tuser  = '0;   // kind [1:0]
   logic        req_tlast  = 1'b0; // last_item
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // overlap_count [10:0], zero fill [15:11]
   logic        rsp_tlast;         // last_query

   // bench copy of the reference set
   pos_type     set_lo [MAX_INTERVALS];
   pos_type     set_hi [MAX_INTERVALS];
   int          set_size  = 0;

   query_answer_type answers_due [$];
   int          errors    = 0;
   int          n_sent    = 0;
   int          cycles    = 0;
   bit          calm      = 1'b0;
   int          rsp_stall = 0;

   interval_overlap_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("tb: mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   // closed intervals overlap unless one lies wholly past the other
   function automatic count_type count_overlaps(input pos_type lo, input pos_type hi);
      int hits;
      hits = 0;
      for (int i = 0; i < set_size; i++) begin
         if (!(hi < set_lo[i] || lo > set_hi[i]) && hits < COUNT_CAP) begin
            hits++;
         end
      end
      return count_type'(hits);
   endfunction

   // interval in one of three position ranges: low, anywhere, top
   task automatic pick_span(input int unsigned zone, output pos_type lo, output pos_type hi);
      pos_type tmp;
      case (zone)
         0: begin
            lo = pos_type'($urandom_range(0, 1000));
            hi = lo + pos_type'($urandom_range(0, 60));
         end
         1: begin
            lo = pos_type'($urandom);
            hi = lo + (pos_type'($urandom) >> $urandom_range(0, 31));
            if (hi < lo) begin
               hi = '1;
            end
         end
         default: begin
            lo = 32'hFFFF_FFFF - pos_type'($urandom_range(0, 1000));
            hi = lo + pos_type'($urandom_range(0, 60));
            if (hi < lo) begin
               hi = '1;
            end
         end
      endcase
      // now and then an inverted interval
      if ($urandom_range(0, 9) == 0) begin
         tmp = lo;
         lo  = hi;
         hi  = tmp;
      end
   endtask

   // drive one word, wait for its handshake, then update the bench set
   task automatic put_item(input logic [1:0] kind, input pos_type lo, input pos_type hi,
                           input logic last, input logic known, input count_type typed);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {hi, lo};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      case (kind)
         KIND_LOAD: begin
            // loads into a full set are dropped
            if (set_size < MAX_INTERVALS) begin
               set_lo[set_size] = lo;
               set_hi[set_size] = hi;
               set_size++;
            end
         end
         KIND_CLEAR: begin
            set_size = 0;
         end
         KIND_QUERY: begin
            answers_due.push_back(query_answer_type'{known ? typed : count_overlaps(lo, hi),
                                                     last});
         end
         default: begin
         end
      endcase
      if (kind != KIND_SPARE) begin
         n_sent++;
      end
   endtask

   // response side: check each accepted word, stall in random bursts
   always @(posedge clock) begin
      query_answer_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("unexpected answer count=%0d", rsp_tdata[10:0]));
            end else begin
               want = answers_due.pop_front();
               if (rsp_tdata[COUNT_W-1:0] !== want.count) begin
                  report_mismatch($sformatf("overlap count %0d, expected %0d",
                                            rsp_tdata[COUNT_W-1:0], want.count));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch($sformatf("last flag %b, expected %b", rsp_tlast, want.last));
               end
               if (rsp_tdata[15:COUNT_W] !== '0) begin
                  report_mismatch($sformatf("fill bits %b not zero", rsp_tdata[15:COUNT_W]));
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            rsp_stall  <= $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int unsigned zone;
      int          n_loads;
      int          n_queries;
      pos_type     lo;
      pos_type     hi;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < N_ROWS; r++) begin
         put_item(DIRECTED[r].kind, DIRECTED[r].lo, DIRECTED[r].hi, DIRECTED[r].last,
                  DIRECTED[r].known, DIRECTED[r].count);
      end

      // random batches
      while (n_sent < ITEM_TARGET) begin
         calm = (n_sent >= ITEM_TARGET - CALM_TAIL);
         if ($urandom_range(0, 9) == 0) begin
            // noise: any kind, any fields
            repeat ($urandom_range(1, 6)) begin
               put_item(2'($urandom_range(0, 3)), pos_type'($urandom), pos_type'($urandom),
                        1'($urandom_range(0, 1)), 1'b0, '0);
            end
         end else begin
            // well-formed batch: maybe clear, loads, then queries closing with last
            zone      = $urandom_range(0, 2);
            n_loads   = $urandom_range(1, 24);
            n_queries = $urandom_range(1, 10);
            if ($urandom_range(0, 2) == 0) begin
               put_item(KIND_CLEAR, pos_type'($urandom), pos_type'($urandom),
                        1'($urandom_range(0, 1)), 1'b0, '0);
            end
            for (int i = 0; i < n_loads; i++) begin
               pick_span(zone, lo, hi);
               put_item(KIND_LOAD, lo, hi, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
            for (int i = 0; i < n_queries; i++) begin
               pick_span(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : zone, lo, hi);
               put_item(KIND_QUERY, lo, hi,
                        (i == n_queries - 1) || ($urandom_range(0, 7) == 0), 1'b0, '0);
            end
         end
      end
      req_tvalid <= 1'b0;

      // wait out the answers, then a few scans more for strays
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && answers_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
